@@ hw/rtl/ufm_pkg.sv @@
package ufm_pkg;

	localparam int NODES       = 1024;
	localparam int NODE_W      = $clog2(NODES);
	localparam int SIZE_W      = $clog2(NODES + 1);
	localparam int PROD_W      = 19;
	localparam int TOTAL_W     = 20;
	localparam int OUT_TOTAL_W = 19;

	localparam int IN_TDATA_W  = ((2 * NODE_W + 7) / 8) * 8;
	localparam int OUT_FIELD_W = 1 + PROD_W + OUT_TOTAL_W;
	localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

	localparam logic [NODE_W:0]   NODE_LIM  = (NODE_W + 1)'(NODES);
	localparam logic [NODE_W-1:0] CLR_LAST  = NODE_W'(NODES - 1);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_WALK,
		ST_COMP,
		ST_SZA,
		ST_SZB,
		ST_DONE
	} seq_state_t;

	// write request to the parent table
	typedef struct packed {
		logic              en;
		logic [NODE_W-1:0] addr;
		logic [NODE_W-1:0] data;
	} par_wr_t;

	// write request to the size table
	typedef struct packed {
		logic              en;
		logic [NODE_W-1:0] addr;
		logic [SIZE_W-1:0] data;
	} size_wr_t;

	// finished lookup handed to the product / total stage
	typedef struct packed {
		logic              vld;
		logic              merged;
		logic              count;
		logic [SIZE_W-1:0] size_a;
		logic [SIZE_W-1:0] size_b;
	} seq_req_t;

endpackage

@@ hw/rtl/ufm_ram.sv @@
module ufm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

@@ hw/rtl/ufm_seq.sv @@
module ufm_seq (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic                       in_count,
	input  logic [ufm_pkg::NODE_W-1:0] in_a,
	input  logic [ufm_pkg::NODE_W-1:0] in_b,
	input  logic [ufm_pkg::NODE_W-1:0] p_rdata,
	input  logic [ufm_pkg::SIZE_W-1:0] s_rdata,
	output logic                       rd_en,
	output logic [ufm_pkg::NODE_W-1:0] rd_addr,
	output ufm_pkg::par_wr_t           pw,
	output ufm_pkg::size_wr_t          sw,
	output ufm_pkg::seq_req_t          req,
	input  logic                       req_rdy
);

	import ufm_pkg::*;

	seq_state_t        state_q, state_d;
	logic [NODE_W-1:0] clr_q;
	logic              phase_q;

	logic [NODE_W-1:0] node_a_q, node_b_q, cur_q;
	logic [NODE_W-1:0] root_a_q, root_b_q;
	logic [SIZE_W-1:0] size_a_q, size_b_q;
	logic              count_q, merged_q;

	logic [NODE_W-1:0] start_node, root_cur, root_lo, root_hi;
	logic              in_range, at_root;

	assign in_range   = ({1'b0, in_a} < NODE_LIM) && ({1'b0, in_b} < NODE_LIM);
	assign start_node = phase_q ? node_b_q : node_a_q;
	assign root_cur   = phase_q ? root_b_q : root_a_q;
	assign root_lo    = (root_a_q < root_b_q) ? root_a_q : root_b_q;
	assign root_hi    = (root_a_q < root_b_q) ? root_b_q : root_a_q;
	assign at_root    = (p_rdata == cur_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
			phase_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + NODE_W'(1);
			end
			if (state_q == ST_IDLE) begin
				phase_q <= 1'b0;
			end else if (state_q == ST_COMP && cur_q == root_cur) begin
				phase_q <= 1'b1;
			end
		end
	end

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		rd_en    = 1'b0;
		rd_addr  = cur_q;
		pw       = '0;
		sw       = '0;
		unique case (state_q)
			ST_CLEAR: begin
				pw.en   = 1'b1;
				pw.addr = clr_q;
				pw.data = clr_q;
				sw.en   = 1'b1;
				sw.addr = clr_q;
				sw.data = SIZE_W'(1);
				if (clr_q == CLR_LAST) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (in_range) begin
						rd_en   = 1'b1;
						rd_addr = in_a;
						state_d = ST_WALK;
					end else begin
						state_d = ST_DONE;
					end
				end
			end
			ST_WALK: begin
				rd_en = 1'b1;
				if (at_root) begin
					rd_addr = start_node;
					state_d = ST_COMP;
				end else begin
					rd_addr = p_rdata;
				end
			end
			ST_COMP: begin
				if (cur_q == root_cur) begin
					if (!phase_q) begin
						rd_en   = 1'b1;
						rd_addr = node_b_q;
						state_d = ST_WALK;
					end else if (root_a_q == root_b_q) begin
						state_d = ST_DONE;
					end else begin
						rd_en   = 1'b1;
						rd_addr = root_a_q;
						state_d = ST_SZA;
					end
				end else begin
					// point this node at the root, fetch the next one up
					pw.en   = 1'b1;
					pw.addr = cur_q;
					pw.data = root_cur;
					rd_en   = 1'b1;
					rd_addr = p_rdata;
				end
			end
			ST_SZA: begin
				rd_en   = 1'b1;
				rd_addr = root_b_q;
				state_d = ST_SZB;
			end
			ST_SZB: begin
				pw.en   = 1'b1;
				pw.addr = root_hi;
				pw.data = root_lo;
				sw.en   = 1'b1;
				sw.addr = root_lo;
				sw.data = size_a_q + s_rdata;
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (req_rdy) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					node_a_q <= in_a;
					node_b_q <= in_b;
					count_q  <= in_count;
					cur_q    <= in_a;
					merged_q <= 1'b0;
				end
			end
			ST_WALK: begin
				if (at_root) begin
					if (phase_q) begin
						root_b_q <= cur_q;
					end else begin
						root_a_q <= cur_q;
					end
					cur_q <= start_node;
				end else begin
					cur_q <= p_rdata;
				end
			end
			ST_COMP: begin
				if (cur_q == root_cur) begin
					cur_q <= node_b_q;
				end else begin
					cur_q <= p_rdata;
				end
			end
			ST_SZA: begin
				size_a_q <= s_rdata;
			end
			ST_SZB: begin
				size_b_q <= s_rdata;
				merged_q <= 1'b1;
			end
			default: begin
			end
		endcase
	end

	assign req.vld    = (state_q == ST_DONE);
	assign req.merged = merged_q;
	assign req.count  = count_q;
	assign req.size_a = size_a_q;
	assign req.size_b = size_b_q;

	a_comp_no_collide: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_COMP && pw.en && rd_en) |-> (pw.addr != rd_addr))
		else $error("compression write hits the entry being read");

	a_walk_downward: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WALK) |-> (p_rdata <= cur_q))
		else $error("parent above its child during walk");

	a_merge_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SZB) |-> (pw.data < pw.addr && sw.addr == pw.data))
		else $error("merge does not hang higher root under lower root");

endmodule

@@ hw/rtl/ufm_acc.sv @@
module ufm_acc (
	input  logic                            clk,
	input  logic                            arst_n,
	input  ufm_pkg::seq_req_t               req,
	output logic                            req_rdy,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic                            out_merged,
	output logic [ufm_pkg::PROD_W-1:0]      out_product,
	output logic [ufm_pkg::OUT_TOTAL_W-1:0] out_total
);

	import ufm_pkg::*;

	logic                  v_s1;
	logic                  merged_s1, count_s1;
	logic [PROD_W-1:0]     prod_s1;
	logic [2*SIZE_W-1:0]   mul_full;
	logic [TOTAL_W-1:0]    total_q, total_next;
	logic                  drain;

	assign req_rdy    = !v_s1;
	assign mul_full   = (2*SIZE_W)'(req.size_a) * (2*SIZE_W)'(req.size_b);
	assign drain      = v_s1 && (!out_valid || out_ready);
	assign total_next = total_q + ((count_s1 && merged_s1) ? TOTAL_W'(prod_s1) : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			out_valid <= 1'b0;
			total_q   <= '0;
		end else begin
			if (req.vld && req_rdy) begin
				v_s1 <= 1'b1;
			end else if (drain) begin
				v_s1 <= 1'b0;
			end
			if (drain) begin
				out_valid <= 1'b1;
				total_q   <= total_next;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.vld && req_rdy) begin
			merged_s1 <= req.merged;
			count_s1  <= req.count;
			prod_s1   <= req.merged ? PROD_W'(mul_full) : '0;
		end
		if (drain) begin
			out_merged  <= merged_s1;
			out_product <= prod_s1;
			out_total   <= OUT_TOTAL_W'(total_next);
		end
	end

	a_total_moves_on_drain: assert property (@(posedge clk) disable iff (!arst_n)
		!drain |=> $stable(total_q))
		else $error("running total changed without a finished item");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(out_merged)
			&& $stable(out_product) && $stable(out_total)))
		else $error("result changed while waiting for transfer");

	a_no_merge_zero_product: assert property (@(posedge clk) disable iff (!arst_n)
		(req.vld && req_rdy && !req.merged) |=> (v_s1 && prod_s1 == '0))
		else $error("nonzero product for an item without merge");

endmodule

@@ hw/rtl/union_find_merge_with_size_product.sv @@
// disjoint-set merge engine: parent and size tables in two srams with registered reads
// a new input is taken only after the sequencer has handed the last lookup to the
// product stage; each walk/compress step is one read of the parent sram, and the
// sizes need two more reads of the size sram
// reset (arst_n low): after release a clearing pass fills both tables, no input taken
module union_find_merge_with_size_product (
	input  logic                                clk,
	input  logic                                arst_n,
	// input stream
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	input  logic [ufm_pkg::IN_TDATA_W-1:0]      s_axis_tdata,  // node_a, node_b, zero pad
	input  logic                                s_axis_tuser,  // opcode
	// result stream
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	output logic [ufm_pkg::OUT_TDATA_W-1:0]     m_axis_tdata   // merged, size_product,
	                                                           // running_total, zero pad
);

	import ufm_pkg::*;

	logic [NODE_W-1:0]      node_a, node_b;
	logic [NODE_W-1:0]      p_rdata, rd_addr;
	logic [SIZE_W-1:0]      s_rdata;
	logic                   rd_en;
	par_wr_t                pw;
	size_wr_t               sw;
	seq_req_t               req;
	logic                   req_rdy;
	logic                   out_merged;
	logic [PROD_W-1:0]      out_product;
	logic [OUT_TOTAL_W-1:0] out_total;

	// unpack the input transfer: node_a in the low bits
	assign node_a = s_axis_tdata[NODE_W-1:0];
	assign node_b = s_axis_tdata[2*NODE_W-1:NODE_W];

	// parent table: one entry per node, points toward the root
	ufm_ram #(
		.WIDTH(NODE_W),
		.DEPTH(NODES)
	) u_parent (
		.clk    (clk),
		.wr_en  (pw.en),
		.wr_addr(pw.addr),
		.wr_data(pw.data),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(p_rdata)
	);

	// size table: only root entries are kept up to date
	ufm_ram #(
		.WIDTH(SIZE_W),
		.DEPTH(NODES)
	) u_size (
		.clk    (clk),
		.wr_en  (sw.en),
		.wr_addr(sw.addr),
		.wr_data(sw.data),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(s_rdata)
	);

	// sequencer: table fill, root walk, path compression, merge write-back
	ufm_seq u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(s_axis_tvalid),
		.in_ready(s_axis_tready),
		.in_count(s_axis_tuser),
		.in_a    (node_a),
		.in_b    (node_b),
		.p_rdata (p_rdata),
		.s_rdata (s_rdata),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.pw      (pw),
		.sw      (sw),
		.req     (req),
		.req_rdy (req_rdy)
	);

	// size product, running total and the output register
	ufm_acc u_acc (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.req_rdy    (req_rdy),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_merged (out_merged),
		.out_product(out_product),
		.out_total  (out_total)
	);

	// pack the result transfer: merged in bit 0
	assign m_axis_tdata = OUT_TDATA_W'({out_total, out_product, out_merged});

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 100ps

module testbench;
	import ufm_pkg::*;

	localparam logic OP_MERGE = 1'b0;  // merge only
	localparam logic OP_COUNT = 1'b1;  // merge and add the size product to the total

	localparam int BLOCK       = 64;
	localparam int NUM_BLOCKS  = NODES / BLOCK;
	localparam int CYCLE_LIMIT = 2_000_000;

	// one result transfer as it sits in m_axis_tdata, lowest field last
	typedef struct packed {
		logic [OUT_TOTAL_W-1:0] total;
		logic [PROD_W-1:0]      product;
		logic                   merged;
	} link_result_t;

	// shadow disjoint-set tables plus the queue of results still owed by the block
	class merge_tracker;
		logic [NODE_W-1:0]  parent_of [NODES];
		logic [SIZE_W-1:0]  comp_size [NODES];
		logic [TOTAL_W-1:0] sum_total;
		link_result_t       pending_links [$];
		int                 errors;
		int                 links_seen;
		int                 merges_seen;
		int                 counted_merges;
		logic [PROD_W-1:0]  biggest_product;

		function new();
			for (int i = 0; i < NODES; i++) begin
				parent_of[i] = NODE_W'(i);
				comp_size[i] = SIZE_W'(1);
			end
			sum_total       = '0;
			errors          = 0;
			links_seen      = 0;
			merges_seen     = 0;
			counted_merges  = 0;
			biggest_product = '0;
		endfunction

		// root lookup; every node on the way is pointed straight at the root
		function logic [NODE_W-1:0] find_root(logic [NODE_W-1:0] n);
			logic [NODE_W-1:0] r;
			logic [NODE_W-1:0] p;
			r = n;
			while (parent_of[r] != r)
				r = parent_of[r];
			while (n != r) begin
				p = parent_of[n];
				parent_of[n] = r;
				n = p;
			end
			return r;
		endfunction

		// accepted input: update the shadow tables and queue the expected result
		function void note_link(logic op, logic [NODE_W-1:0] a, logic [NODE_W-1:0] b);
			logic [NODE_W-1:0]   ra;
			logic [NODE_W-1:0]   rb;
			logic [NODE_W-1:0]   lo;
			logic [NODE_W-1:0]   hi;
			logic [2*SIZE_W-1:0] prod;
			logic [SIZE_W-1:0]   joined;
			link_result_t        want;
			links_seen++;
			ra = find_root(a);
			rb = find_root(b);
			want = '0;
			if (ra != rb) begin
				prod   = (2*SIZE_W)'(comp_size[ra]) * (2*SIZE_W)'(comp_size[rb]);
				joined = comp_size[ra] + comp_size[rb];
				lo = (ra < rb) ? ra : rb;
				hi = (ra < rb) ? rb : ra;
				parent_of[hi] = lo;
				comp_size[lo] = joined;
				if (op == OP_COUNT) begin
					sum_total = sum_total + TOTAL_W'(prod);
					counted_merges++;
				end
				merges_seen++;
				want.merged  = 1'b1;
				want.product = prod[PROD_W-1:0];
				if (want.product > biggest_product)
					biggest_product = want.product;
			end
			want.total = sum_total[OUT_TOTAL_W-1:0];
			pending_links = {pending_links, want};
		endfunction

		// accepted result: compare field by field with the oldest expectation
		function void check_result(logic [OUT_TDATA_W-1:0] word);
			link_result_t got;
			link_result_t want;
			got = word[OUT_FIELD_W-1:0];
			if (pending_links.size() == 0) begin
				errors++;
				$display("%0t: unexpected result, merged %0d product %0d total %0d",
					$time, got.merged, got.product, got.total);
				return;
			end
			want = pending_links.pop_front();
			if (got.merged !== want.merged) begin
				errors++;
				$display("%0t: merged mismatch, expected %0d actual %0d",
					$time, want.merged, got.merged);
			end
			if (got.product !== want.product) begin
				errors++;
				$display("%0t: size_product mismatch, expected %0d actual %0d",
					$time, want.product, got.product);
			end
			if (got.total !== want.total) begin
				errors++;
				$display("%0t: running_total mismatch, expected %0d actual %0d",
					$time, want.total, got.total);
			end
		endfunction
	endclass

	logic                   clk           = 1'b0;
	logic                   arst_n        = 1'b0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;   // node_a, node_b, zero pad
	logic                   s_axis_tuser  = 1'b0; // opcode
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;         // merged, size_product, running_total, pad

	merge_tracker tracker = new();

	// upper bounds of the per-transfer idle draws; zero gives back-to-back stretches
	int tx_gap_max   = 6;
	int rx_stall_max = 6;

	int unsigned cycle_count = 0;

	union_find_merge_with_size_product dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// watchdog: covers the clearing pass after reset and the deepest walks many times over
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycle_count, tracker.pending_links.size());
			$display("Simulation FAILED");
			$finish;
		end
	end

	function automatic logic rand_op();
		return $urandom_range(0, 1) ? OP_COUNT : OP_MERGE;
	endfunction

	// one input transfer after a random idle gap; valid stays high across back-to-back items
	task automatic send_link(input logic op, input int a, input int b);
		int gap;
		gap = $urandom_range(0, tx_gap_max);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= op;
		s_axis_tdata  <= IN_TDATA_W'({NODE_W'(b), NODE_W'(a)});
		do @(posedge clk); while (!s_axis_tready);
		tracker.note_link(op, NODE_W'(a), NODE_W'(b));
	endtask

	// hold the input side until every expected result has come back
	task automatic wait_results();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (tracker.pending_links.size() != 0);
	endtask

	// result side: random stall before each transfer, then take whatever comes
	initial begin : result_sink
		int stall;
		@(posedge clk);
		forever begin
			stall = $urandom_range(0, rx_stall_max);
			if (stall > 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
			tracker.check_result(m_axis_tdata);
		end
	end

	initial begin : stimulus
		int base;
		int half;
		int a;
		int b;
		int n;
		int span;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// directed: same node, extremes, repeat link, uncounted merge
		send_link(OP_COUNT, 0, 0);
		send_link(OP_COUNT, NODES - 1, NODES - 1);
		send_link(OP_COUNT, 0, 1);
		send_link(OP_COUNT, 1, 0);
		send_link(OP_MERGE, NODES - 1, NODES - 2);
		send_link(OP_COUNT, NODES - 2, NODES - 3);
		// descending links build one long parent chain under the top nodes
		for (int i = NODES - 3; i > NODES - 13; i--)
			send_link(rand_op(), i, i - 1);
		// deep walk with compression, then the same component again
		send_link(OP_COUNT, NODES - 1, NODES - 64);
		send_link(OP_MERGE, NODES - 1, NODES - 12);
		send_link(OP_COUNT, 2, 3);
		send_link(OP_MERGE, 3, 1);
		wait_results();

		// random links inside each block of nodes, then a sweep that joins the block;
		// odd blocks sweep downward so parent chains grow deep before compression
		for (int blk = 0; blk < NUM_BLOCKS; blk++) begin
			base = blk * BLOCK;
			half = (blk / (NUM_BLOCKS / 2)) * (NODES / 2);
			tx_gap_max   = (blk % 4 == 3) ? 0 : 6;
			rx_stall_max = (blk % 4 == 1 || blk % 4 == 3) ? 0 : 6;
			repeat (50) begin
				a = base + $urandom_range(0, BLOCK - 1);
				// occasional stray link, kept inside its half so the halves stay apart
				if ($urandom_range(0, 19) == 0)
					b = half + $urandom_range(0, NODES / 2 - 1);
				else
					b = base + $urandom_range(0, BLOCK - 1);
				send_link(rand_op(), a, b);
			end
			for (int i = 1; i < BLOCK; i++) begin
				n = (blk % 2 == 0) ? i : BLOCK - i;
				if ($urandom_range(0, 1))
					send_link(rand_op(), base + n, base + n - 1);
				else
					send_link(rand_op(), base + n - 1, base + n);
			end
		end
		tx_gap_max   = 6;
		rx_stall_max = 6;
		wait_results();

		// pairwise joins of ever larger groups; the last one joins two halves of 512
		for (span = BLOCK; span < NODES; span *= 2) begin
			for (int lo = 0; lo < NODES; lo += 2 * span)
				send_link((span == NODES / 2) ? OP_COUNT : rand_op(),
					lo + $urandom_range(0, span - 1),
					lo + span + $urandom_range(0, span - 1));
			wait_results();
		end

		// everything is one component now: only no-merge results remain
		send_link(OP_COUNT, 0, NODES - 1);
		send_link(OP_MERGE, NODES - 1, 0);
		repeat (30)
			send_link(rand_op(), $urandom_range(0, NODES - 1), $urandom_range(0, NODES - 1));

		wait_results();
		repeat (64) @(posedge clk);

		$display("ran %0d links: %0d merges, %0d of them counted, largest size product %0d",
			tracker.links_seen, tracker.merges_seen, tracker.counted_merges,
			tracker.biggest_product);
		$display("final running total %0d, %0d field mismatches",
			tracker.sum_total[OUT_TOTAL_W-1:0], tracker.errors);
		if (tracker.errors == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

@@ sim.f @@
hw/rtl/ufm_pkg.sv
hw/rtl/ufm_ram.sv
hw/rtl/ufm_seq.sv
hw/rtl/ufm_acc.sv
hw/rtl/union_find_merge_with_size_product.sv
verif/testbench.sv
